/* rtl/core/gsnr_pkg.sv */
// gsnr_pkg: shared constants and types for the grid sparse neighbor removal block
// no dependencies; used by rtl/core/grid_sparse_neighbor_removal.sv and sim/grid_sparse_neighbor_removal_test.sv

package gsnr_pkg;

    // grid size limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 4096;

    // derived widths
    localparam int COL_W = $clog2(MAX_WIDTH);        // column index / line buffer address
    localparam int WID_W = $clog2(MAX_WIDTH + 1);    // stored grid width
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);   // row index, runs to height+1 in flush

    // register field widths as seen on the configuration port
    localparam int GW_FIELD_W  = 9;
    localparam int GH_FIELD_W  = 13;
    localparam int THR_W       = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // removal count
    localparam int CNT_W = 21;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // reset values of the registers
    localparam int RST_WIDTH     = (256 < MAX_WIDTH) ? 256 : MAX_WIDTH;
    localparam int RST_HEIGHT    = (256 < MAX_HEIGHT) ? 256 : MAX_HEIGHT;
    localparam int RST_THRESHOLD = 4;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_NEIGHBOR_THRESHOLD = 2'd2,
        REG_UNUSED = 2'd3
    } cfg_index_t;

    // one 3x3 window column: bit 0 top row, bit 1 middle, bit 2 bottom
    typedef logic [2:0] win_col_t;

    // one line buffer entry: cell two rows up and cell one row up
    typedef struct packed {
        logic center;
        logic above;
    } line_entry_t;

endpackage

/* rtl/core/grid_sparse_neighbor_removal.sv */
// grid_sparse_neighbor_removal: streaming 3x3 neighbor-count removal filter on a binary grid
// depends on gsnr_pkg (constants, register indexes, line buffer entry type)

// The block takes one raster cell per clock while results are taken and gives at most one
// result per cell, with no stall of its own: the line buffer does one read and one write per
// cycle and is read one column ahead so that each cell is handled in the cycle it is
// accepted. A cell's result comes out grid_width+1 beats after the cell itself, via the
// output register, so the host sends grid_width+1 pad beats after each frame; the result
// for the frame's last cell carries tlast and the frame's removal count, and the block
// then restarts for the next frame. No clearing pass is needed after reset: the first two
// rows of every frame mask the line buffer. Configuration writes to listed registers
// restart the frame and must only be sent while the block is idle.

module grid_sparse_neighbor_removal (
    input  logic                               aclk,
    input  logic                               aresetn,

    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gsnr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gsnr_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input cells
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [gsnr_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] cell_occupied, [7:1] zero
    input  logic                               s_tuser,   // [0] pad

    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gsnr_pkg::M_TDATA_W-1:0]     m_tdata,   // [0] cell_after, [1] removed,
                                                          // [22:2] removed_count, [23] zero
    output logic                               m_tlast    // last_cell
);

    localparam int COL_W = gsnr_pkg::COL_W;
    localparam int WID_W = gsnr_pkg::WID_W;
    localparam int ROW_W = gsnr_pkg::ROW_W;
    localparam int CNT_W = gsnr_pkg::CNT_W;
    localparam int THR_W = gsnr_pkg::THR_W;

    // registers
    logic [WID_W-1:0]          width_reg;
    logic [ROW_W-1:0]          height_reg;
    logic [THR_W-1:0]          thr_reg;

    logic [COL_W-1:0]          col_reg,    col_next;
    logic [ROW_W-1:0]          row_reg,    row_next;
    logic [8:0]                window_reg, window_next;
    logic [CNT_W-1:0]          total_reg,  total_next;
    logic [CNT_W-1:0]          total_inc;

    gsnr_pkg::line_entry_t     line_mem [gsnr_pkg::MAX_WIDTH];
    gsnr_pkg::line_entry_t     line_rd_reg;
    logic [COL_W-1:0]          rd_addr;

    logic                      m_valid_reg;
    logic                      cell_after_reg;
    logic                      removed_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          count_reg;

    // handshakes
    logic                      in_beat;
    logic                      cfg_beat;

    // per-cell decision logic
    logic                      cell_v;
    logic                      top_bit;
    logic                      mid_bit;
    gsnr_pkg::win_col_t        new_col;
    gsnr_pkg::win_col_t        left_col;
    gsnr_pkg::win_col_t        mid_col;
    gsnr_pkg::win_col_t        right_col;
    logic [3:0]                nbr_count;
    logic                      rem;
    logic                      dec_valid;
    logic                      dec_last;
    logic [ROW_W-1:0]          h_plus1;
    logic [WID_W:0]            col_inc;
    logic                      frame_end;

    // configuration clamping
    logic [gsnr_pkg::GW_FIELD_W-1:0] cfg_w;
    logic [gsnr_pkg::GH_FIELD_W-1:0] cfg_h;

    function automatic logic [1:0] ones3(input gsnr_pkg::win_col_t c);
        ones3 = {1'b0, c[0]} + {1'b0, c[1]} + {1'b0, c[2]};
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    // incoming cell, empty for pads and rows past the frame
    assign cell_v  = s_tdata[0] && !s_tuser && (row_reg < height_reg);

    // line buffer taps, masked in the first rows of a frame
    assign top_bit = line_rd_reg.above  && (row_reg >= ROW_W'(2));
    assign mid_bit = line_rd_reg.center && (row_reg >= ROW_W'(1));
    assign new_col = {cell_v, mid_bit, top_bit};

    // window columns around the decided cell; grid edges read as empty
    assign left_col  = (col_reg == COL_W'(1)) ? 3'b000 : window_reg[5:3];
    assign mid_col   = window_reg[8:6];
    assign right_col = (col_reg == '0) ? 3'b000 : new_col;

    assign nbr_count = {2'b00, ones3(left_col)} + {2'b00, ones3(right_col)}
                     + {3'b000, mid_col[0]} + {3'b000, mid_col[2]};
    assign rem       = mid_col[1] && (nbr_count < thr_reg);

    // which beats carry a result
    assign h_plus1   = height_reg + ROW_W'(1);
    assign dec_valid = (col_reg == '0) ? (row_reg >= ROW_W'(2))
                                       : ((row_reg >= ROW_W'(1)) && (row_reg < h_plus1));
    assign dec_last  = (col_reg == '0) && (row_reg == h_plus1);
    assign frame_end = (col_reg == '0) && (row_reg >= h_plus1);
    assign col_inc   = {1'b0, WID_W'(col_reg)} + (WID_W+1)'(1);

    // removal count including the decided cell, saturating
    assign total_inc = (dec_valid && rem && (total_reg != {CNT_W{1'b1}}))
                     ? total_reg + CNT_W'(1) : total_reg;

    // next frame position, window and count
    always_comb begin
        total_next  = total_inc;
        window_next = {new_col, window_reg[8:3]};
        col_next    = col_reg + COL_W'(1);
        row_next    = row_reg;
        if (frame_end) begin
            window_next = '0;
            col_next    = '0;
            row_next    = '0;
            total_next  = '0;
        end else if (col_inc >= {1'b0, width_reg}) begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
    end

    // line buffer read one column ahead of the accepted beat
    assign rd_addr = in_beat ? col_next : col_reg;

    always_ff @(posedge aclk) begin
        line_rd_reg <= line_mem[rd_addr];
        if (in_beat) begin
            line_mem[col_reg] <= '{center: cell_v, above: line_rd_reg.center};
        end
    end

    assign cfg_w = cfg_data[gsnr_pkg::GW_FIELD_W-1:0];
    assign cfg_h = cfg_data[gsnr_pkg::GH_FIELD_W-1:0];

    // control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WID_W'(gsnr_pkg::RST_WIDTH);
            height_reg <= ROW_W'(gsnr_pkg::RST_HEIGHT);
            thr_reg    <= THR_W'(gsnr_pkg::RST_THRESHOLD);
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
            total_reg  <= '0;
        end else if (cfg_beat) begin
            // a write to a listed register restarts the frame
            case (gsnr_pkg::cfg_index_t'(cfg_index))
                gsnr_pkg::REG_GRID_WIDTH: begin
                    if (cfg_w < 2) begin
                        width_reg <= WID_W'(2);
                    end else if (cfg_w > gsnr_pkg::MAX_WIDTH) begin
                        width_reg <= WID_W'(gsnr_pkg::MAX_WIDTH);
                    end else begin
                        width_reg <= WID_W'(cfg_w);
                    end
                end
                gsnr_pkg::REG_GRID_HEIGHT: begin
                    if (cfg_h < 2) begin
                        height_reg <= ROW_W'(2);
                    end else if (cfg_h > gsnr_pkg::MAX_HEIGHT) begin
                        height_reg <= ROW_W'(gsnr_pkg::MAX_HEIGHT);
                    end else begin
                        height_reg <= ROW_W'(cfg_h);
                    end
                end
                gsnr_pkg::REG_NEIGHBOR_THRESHOLD: begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
            if (gsnr_pkg::cfg_index_t'(cfg_index) != gsnr_pkg::REG_UNUSED) begin
                col_reg    <= '0;
                row_reg    <= '0;
                window_reg <= '0;
                total_reg  <= '0;
            end
        end else if (in_beat) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            window_reg <= window_next;
            total_reg  <= total_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_beat) begin
            m_valid_reg <= dec_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat && dec_valid) begin
            cell_after_reg <= mid_col[1] && !rem;
            removed_reg    <= rem;
            last_reg       <= dec_last;
            count_reg      <= total_inc;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(gsnr_pkg::M_TDATA_W - CNT_W - 2){1'b0}},
                       count_reg, removed_reg, cell_after_reg};
    assign m_tlast  = last_reg;

endmodule

/* sim/grid_sparse_neighbor_removal_test.sv */
// grid_sparse_neighbor_removal_test: self-checking bench for the 3x3 neighbor removal filter
// depends on gsnr_pkg and grid_sparse_neighbor_removal; predicts every result beat locally

`timescale 1ns / 100ps

module grid_sparse_neighbor_removal_test;

    localparam int          CNT_W         = gsnr_pkg::CNT_W;
    localparam int          CFG_INDEX_W   = gsnr_pkg::CFG_INDEX_W;
    localparam int          CFG_DATA_W    = gsnr_pkg::CFG_DATA_W;
    localparam int          S_TDATA_W     = gsnr_pkg::S_TDATA_W;
    localparam int          M_TDATA_W     = gsnr_pkg::M_TDATA_W;
    localparam int          MAX_WIDTH     = gsnr_pkg::MAX_WIDTH;
    localparam int          MAX_HEIGHT    = gsnr_pkg::MAX_HEIGHT;
    localparam int          GW_FIELD_W    = gsnr_pkg::GW_FIELD_W;
    localparam int          GH_FIELD_W    = gsnr_pkg::GH_FIELD_W;
    localparam int          THR_W         = gsnr_pkg::THR_W;

    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned COUNT_MAX    = (1 << CNT_W) - 1;
    localparam int          RANDOM_BEATS = 250;

    typedef struct {
        logic             cell_after;
        logic             removed;
        logic             last_cell;
        logic [CNT_W-1:0] removed_count;
    } cell_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [0] cell_occupied, [7:1] zero
    logic                   s_tuser;   // [0] pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [0] cell_after, [1] removed, [22:2] removed_count
    logic                   m_tlast;   // last_cell

    grid_sparse_neighbor_removal u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // bench bookkeeping
    cell_result_t pending_results[$];
    logic         seen_after[$];
    logic [CNT_W-1:0] last_frame_count;
    int           error_count    = 0;
    int           beats_sent     = 0;
    int           results_seen   = 0;
    int           reg_writes     = 0;
    int           frames_closed  = 0;
    bit           idle_enable    = 1'b1;

    // local copy of the filter state
    logic        above_row  [MAX_WIDTH];
    logic        center_row [MAX_WIDTH];
    logic [8:0]  win;       // [2:0] left column, [5:3] middle, [8:6] right; bit 0 top
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned frame_removals;
    int unsigned cfg_width;
    int unsigned cfg_height;
    int unsigned cfg_thr;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run limit
    initial begin
        #(8_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !idle_enable || ($urandom_range(99) >= 6);
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
    endtask

    function automatic int unsigned ones3(input logic [2:0] c);
        return int'(c[0]) + int'(c[1]) + int'(c[2]);
    endfunction

    task automatic restart_frame();
        win            = '0;
        col_pos        = 0;
        row_pos        = 0;
        frame_removals = 0;
    endtask

    // register write as the block stores it
    task automatic apply_reg(input gsnr_pkg::cfg_index_t idx,
                             input logic [CFG_DATA_W-1:0] val);
        int unsigned x;
        case (idx)
            gsnr_pkg::REG_GRID_WIDTH: begin
                x = val[GW_FIELD_W-1:0];
                if (x < 2) x = 2;
                if (x > MAX_WIDTH) x = MAX_WIDTH;
                cfg_width = x;
            end
            gsnr_pkg::REG_GRID_HEIGHT: begin
                x = val[GH_FIELD_W-1:0];
                if (x < 2) x = 2;
                if (x > MAX_HEIGHT) x = MAX_HEIGHT;
                cfg_height = x;
            end
            gsnr_pkg::REG_NEIGHBOR_THRESHOLD: begin
                cfg_thr = val[THR_W-1:0];
            end
            default: return;
        endcase
        restart_frame();
    endtask

    // decide the middle cell of a 3x3 window and queue its result
    task automatic judge_cell(input logic [2:0] lc, input logic [2:0] mc,
                              input logic [2:0] rc, input logic is_last);
        cell_result_t r;
        logic         occ;
        logic         rem;
        int unsigned  nb;
        occ = mc[1];
        nb  = ones3(lc) + ones3(rc) + int'(mc[0]) + int'(mc[2]);
        rem = occ && (nb < cfg_thr);
        if (rem && frame_removals < COUNT_MAX) frame_removals++;
        r.cell_after    = occ & ~rem;
        r.removed       = rem;
        r.last_cell     = is_last;
        r.removed_count = frame_removals[CNT_W-1:0];
        pending_results.push_back(r);
    endtask

    // advance the local filter by one accepted cell
    task automatic predict_cell(input logic occ, input logic pad);
        int unsigned ic;
        int unsigned ir;
        logic        v;
        logic        top;
        logic        mid;
        logic [2:0]  colv;
        ic  = col_pos;
        ir  = row_pos;
        v   = occ && !pad && (ir < cfg_height);
        top = above_row[ic];
        mid = center_row[ic];
        above_row[ic]  = mid;
        center_row[ic] = v;
        if (ir < 2) top = 1'b0;
        if (ir < 1) mid = 1'b0;
        colv = {v, mid, top};
        if (ic == 0) begin
            // first column closes the last column of the row two up
            if (ir >= 2)
                judge_cell(win[5:3], win[8:6], 3'b000, (ir - 2) == cfg_height - 1);
            win = {colv, win[8:3]};
        end else begin
            win = {colv, win[8:3]};
            if (ir >= 1 && ir <= cfg_height)
                judge_cell((ic == 1) ? 3'b000 : win[2:0], win[5:3], win[8:6], 1'b0);
        end
        if (ic == 0 && ir >= cfg_height + 1) begin
            restart_frame();
        end else if (ic + 1 >= cfg_width) begin
            col_pos = 0;
            row_pos = ir + 1;
        end else begin
            col_pos = ic + 1;
        end
    endtask

    // beat monitor: register writes, input prediction, result checking
    always @(posedge aclk) begin : beat_monitor
        cell_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_reg(gsnr_pkg::cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready) predict_cell(s_tdata[0], s_tuser);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[0] !== want.cell_after)
                        report_mismatch($sformatf("cell_after %b, want %b",
                                                  m_tdata[0], want.cell_after));
                    if (m_tdata[1] !== want.removed)
                        report_mismatch($sformatf("removed %b, want %b",
                                                  m_tdata[1], want.removed));
                    if (m_tlast !== want.last_cell)
                        report_mismatch($sformatf("last_cell %b, want %b",
                                                  m_tlast, want.last_cell));
                    if (m_tdata[CNT_W+1:2] !== want.removed_count)
                        report_mismatch($sformatf("removed_count %0d, want %0d",
                                                  m_tdata[CNT_W+1:2], want.removed_count));
                end
                seen_after.push_back(m_tdata[0]);
                if (m_tlast) begin
                    last_frame_count = m_tdata[CNT_W+1:2];
                    frames_closed++;
                end
                results_seen++;
            end
        end
    end

    // one input beat, with random gaps ahead of it
    task automatic send_cell(input logic occ, input logic pad);
        while (idle_enable && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, occ};
        s_tuser  <= pad;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // flush beats that push the last row out
    task automatic send_flush(input int count);
        for (int i = 0; i < count; i++) send_cell(1'($urandom_range(1)), 1'b1);
    endtask

    task automatic send_random_cells(input int count, input int fill_pct, input int pad_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < pad_pct)
                send_cell(1'($urandom_range(1)), 1'b1);
            else
                send_cell($urandom_range(99) < fill_pct, 1'b0);
        end
    endtask

    // wait until every predicted result has arrived and the pipeline is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input gsnr_pkg::cfg_index_t idx,
                             input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    // unused upper bits of width and threshold get random junk
    task automatic set_grid(input int w, input int h, input int thr);
        write_reg(gsnr_pkg::REG_GRID_WIDTH, {4'($urandom), 9'(w)});
        write_reg(gsnr_pkg::REG_GRID_HEIGHT, 13'(h));
        write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, {9'($urandom), 4'(thr)});
    endtask

    // corners of a full grid, threshold zero, pad inside a frame
    task automatic test_directed();
        set_grid(2, 2, 4);
        repeat (4) send_cell(1'b1, 1'b0);
        send_flush(3);
        write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, 13'd0);
        repeat (4) send_cell(1'b1, 1'b0);
        send_flush(3);
        set_grid(3, 3, 8);
        for (int i = 0; i < 9; i++) send_cell(1'b1, i == 1);
        send_flush(4);
    endtask

    // saturation of width and height, out-of-range threshold, unused index
    task automatic test_register_limits();
        // tallest frame: only its first rows are sent
        write_reg(gsnr_pkg::REG_GRID_WIDTH, 13'h1000);
        write_reg(gsnr_pkg::REG_GRID_HEIGHT, 13'h1FFF);
        write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, 13'(4'($urandom_range(1, 6))));
        send_random_cells(64, 60, 0);
        send_flush(cfg_width + 1);
        write_reg(gsnr_pkg::REG_GRID_WIDTH, 13'd511);
        write_reg(gsnr_pkg::REG_GRID_HEIGHT, 13'd1);
        write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, 13'd9);
        send_random_cells(cfg_width * cfg_height, 70, 0);
        send_flush(cfg_width + 1);
        write_reg(gsnr_pkg::REG_GRID_WIDTH, 13'd1);
        write_reg(gsnr_pkg::REG_GRID_HEIGHT, 13'd0);
        write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, 13'd15);
        repeat (4) send_cell(1'b1, 1'b0);
        send_flush(3);
        // unused index mid-frame must leave the frame running
        set_grid(5, 4, 4);
        send_random_cells(10, 70, 0);
        write_reg(gsnr_pkg::REG_UNUSED, 13'($urandom));
        send_random_cells(10, 70, 0);
        send_flush(6);
    endtask

    // feed cell_after back as the next pass until nothing is removed or eight passes are done
    task automatic test_repeated_passes();
        logic grid[$];
        int   passes;
        set_grid(8, 6, 5);
        for (int i = 0; i < 48; i++) grid.push_back($urandom_range(99) < 70);
        passes = 0;
        do begin
            seen_after.delete();
            foreach (grid[i]) send_cell(grid[i], 1'b0);
            send_flush(cfg_width + 1);
            drain();
            grid = seen_after;
            passes++;
        end while (last_frame_count != 0 && passes < 8);
    endtask

    // back-to-back beats on both sides
    task automatic test_steady_stream();
        idle_enable = 1'b0;
        set_grid(16, 8, 3);
        send_random_cells(cfg_width * cfg_height, 50, 2);
        send_flush(cfg_width + 1);
        idle_enable = 1'b1;
    endtask

    // random sizes, thresholds and fill, with some broken flushes
    task automatic test_random_frames();
        int start_beats;
        int w;
        int h;
        int thr;
        int flush_len;
        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            w   = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
            h   = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(2, 8);
            thr = ($urandom_range(4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            if ($urandom_range(2) != 0)
                write_reg(gsnr_pkg::REG_GRID_WIDTH, {4'($urandom), 9'(w)});
            if ($urandom_range(2) != 0)
                write_reg(gsnr_pkg::REG_GRID_HEIGHT, 13'(h));
            if ($urandom_range(2) != 0)
                write_reg(gsnr_pkg::REG_NEIGHBOR_THRESHOLD, {9'($urandom), 4'(thr)});
            send_random_cells(cfg_width * cfg_height, $urandom_range(10, 90), 3);
            flush_len = cfg_width + 1;
            if ($urandom_range(19) == 0) flush_len = $urandom_range(0, cfg_width);
            else if ($urandom_range(19) == 0) flush_len = flush_len + $urandom_range(1, 3);
            send_flush(flush_len);
        end
    endtask

    initial begin : run_tests
        int guard;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gsnr_pkg::REG_GRID_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        foreach (above_row[i]) begin
            above_row[i]  = 1'b0;
            center_row[i] = 1'b0;
        end
        cfg_width        = gsnr_pkg::RST_WIDTH;
        cfg_height       = gsnr_pkg::RST_HEIGHT;
        cfg_thr          = gsnr_pkg::RST_THRESHOLD;
        last_frame_count = '0;
        restart_frame();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_limits();
        test_repeated_passes();
        test_steady_stream();
        test_random_frames();

        // final drain with a bound of its own
        s_tvalid <= 1'b0;
        for (guard = 0; guard < 100000 && pending_results.size() != 0; guard++)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d input beats, %0d result beats, %0d frames closed",
                 beats_sent, results_seen, frames_closed);
        $display("register writes %0d, including saturated and unused index", reg_writes);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* grid_sparse_neighbor_removal.f */
rtl/core/gsnr_pkg.sv
rtl/core/grid_sparse_neighbor_removal.sv
sim/grid_sparse_neighbor_removal_test.sv
